@@ hw/rtl/sustain_pedal_note_holder_assert.svh @@
// Assertion macros shared by the sustain pedal note holder RTL.
`ifndef SUSTAIN_PEDAL_NOTE_HOLDER_ASSERT_SVH
`define SUSTAIN_PEDAL_NOTE_HOLDER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SPNH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SPNH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/spnh_pkg.sv @@
// Types and command codes for the sustain pedal note holder.
package spnh_pkg;

    localparam int unsigned DATA_W = 7;

    localparam logic [1:0] CMD_NOTE  = 2'd0;
    localparam logic [1:0] CMD_VEL   = 2'd1;
    localparam logic [1:0] CMD_PEDAL = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0]        command;
        logic [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] pitch;
        logic [DATA_W-1:0] velocity;
        logic              last;
    } rsp_t;

endpackage

@@ hw/rtl/sustain_pedal_note_holder.sv @@
// Sustain pedal note holder: passes notes, holds note-offs under the pedal, releases them.
//
//   Channel  Dir  Handshake             Beat
//   req      in   req_valid/req_stall   req_t: command, value
//   rsp      out  rsp_valid/rsp_stall   rsp_t: pitch, velocity, last
//
// A note, velocity, clear or pedal-down command is handled when accepted; a passed note
// appears in the output register on the next cycle.
// A pedal release with N held notes first issues a read of the hold memory, then
// emits one released note per cycle from its read port while the output is not stalled.
// Reset clears the velocity, the pedal flag and the hold count; the hold memory
// is not cleared, since only entries below the count are ever read.
// A stalled output holds its beat, and the release burst pauses with it.
module sustain_pedal_note_holder
    import spnh_pkg::*;
#(
    parameter int unsigned HOLD_DEPTH = 32
)
(
    input  logic clk,
    input  logic rst_n,

    input  logic req_valid,
    output logic req_stall,
    input  req_t req,

    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    // The count must be able to hold HOLD_DEPTH itself; the address only indexes entries.
    localparam int unsigned CNT_W  = $clog2(HOLD_DEPTH + 1);
    localparam int unsigned ADDR_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic              state_reg, state_next;
    logic [DATA_W-1:0] vel_reg, vel_next;
    logic              pedal_reg, pedal_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    // Hold stack storage: one write port, one registered read port.
    logic [DATA_W-1:0] mem [HOLD_DEPTH];
    logic [DATA_W-1:0] rdata_reg;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CNT_W-1:0]  count_dec;

    logic out_free;
    logic accept;
    logic full;
    logic pass;

    // The output register can take a new beat when it is empty or being drained.
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !((state_reg == ST_IDLE) && out_free);
    assign accept    = req_valid && !req_stall;

    assign full      = (count_reg == CNT_W'(HOLD_DEPTH));
    assign count_dec = count_reg - CNT_W'(1);
    assign mem_waddr = count_reg[ADDR_W-1:0];
    assign mem_raddr = count_dec[ADDR_W-1:0];

    // A note passes when the velocity is nonzero or the pedal is up.
    assign pass = (vel_reg != '0) || !pedal_reg;

    always_comb
    begin
        state_next     = state_reg;
        vel_next       = vel_reg;
        pedal_next     = pedal_reg;
        count_next     = count_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.command)
                        CMD_NOTE:
                        begin
                            if (pass || full)
                            begin
                                // A note-off that finds the stack full passes with velocity zero.
                                rsp_next.pitch    = req.value;
                                rsp_next.velocity = pass ? vel_reg : '0;
                                rsp_next.last     = 1'b1;
                                rsp_valid_next    = 1'b1;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_VEL:
                        begin
                            vel_next = req.value;
                        end
                        CMD_PEDAL:
                        begin
                            pedal_next = (req.value != '0);
                            if ((req.value == '0) && (count_reg != '0))
                            begin
                                // Fetch the newest held note; the release state emits it.
                                mem_re     = 1'b1;
                                count_next = count_dec;
                                state_next = ST_EMIT;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            ST_EMIT:
            begin
                // Read data holds until it is consumed, so a stall just pauses the burst.
                if (out_free)
                begin
                    rsp_next.pitch    = rdata_reg;
                    rsp_next.velocity = '0;
                    rsp_next.last     = (count_reg == '0);
                    rsp_valid_next    = 1'b1;
                    if (count_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        count_next = count_dec;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Writes come only from an idle note command and reads only from a pedal release or
    // the release state, so the two ports never touch the same entry in one cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= req.value;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vel_reg       <= '0;
            pedal_reg     <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vel_reg       <= vel_next;
            pedal_reg     <= pedal_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`include "sustain_pedal_note_holder_assert.svh"

    // The hold count never exceeds the stack depth.
    `SPNH_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(HOLD_DEPTH),
        "hold count exceeds stack depth")

    // No new command is taken while a release burst is running.
    `SPNH_ASSERT_NOW(a_no_accept_in_emit, state_reg == ST_EMIT, req_stall,
        "command accepted during release")

    // Emitting the oldest held note marks it last and ends the burst.
    `SPNH_ASSERT_NEXT(a_burst_end, (state_reg == ST_EMIT) && out_free && (count_reg == '0),
        (state_reg == ST_IDLE) && rsp_valid && rsp.last,
        "release burst did not end on its last beat")

    // An accepted note-off under the pedal with room left grows the stack.
    `SPNH_ASSERT_NEXT(a_push, accept && (req.command == CMD_NOTE) && !pass && !full,
        count_reg == $past(count_reg) + CNT_W'(1),
        "held note not pushed")

endmodule
